// ----- rtl/core/ohlc_pkg.sv -----
`default_nettype none

package ohlc_pkg;

	// field widths
	localparam int PRICE_BITS  = 40;
	localparam int TIME_BITS   = 40;
	localparam int VOL_IN_BITS = 48;
	localparam int VOL_BITS    = 64;
	localparam int SECS_BITS   = 32;

	// bar length after reset
	localparam logic [SECS_BITS-1:0] SECONDS_RESET = SECS_BITS'(600);

	// remainder unit step counter
	localparam int CNT_BITS = $clog2(TIME_BITS + 1);

	// commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic check;
		logic update;
		logic smooth;
		logic emit;
		logic div_start;
		logic open;
		logic clear;
	} ohlc_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic flush;
		logic in_bar;
		logic active;
		logic div_done;
		logic out_free;
	} ohlc_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/ohlc_rem.sv -----
`default_nettype none

module ohlc_rem (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [ohlc_pkg::TIME_BITS-1:0] dividend,
	input  wire logic [ohlc_pkg::SECS_BITS-1:0] divisor,
	output logic      [ohlc_pkg::SECS_BITS-1:0] rem,
	output logic                               done
);
	import ohlc_pkg::*;

	logic [TIME_BITS-1:0] dvd_q;
	logic [SECS_BITS-1:0] rem_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [SECS_BITS:0]   rem_sh;
	logic [SECS_BITS:0]   rem_sub;

	// one dividend bit per cycle, restoring
	assign rem_sh  = {rem_q, dvd_q[TIME_BITS-1]};
	assign rem_sub = rem_sh - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_BITS'(TIME_BITS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[TIME_BITS-2:0], 1'b0};
			if (rem_sh >= {1'b0, divisor}) begin
				rem_q <= rem_sub[SECS_BITS-1:0];
			end else begin
				rem_q <= rem_sh[SECS_BITS-1:0];
			end
		end
	end

	assign rem  = rem_q;
	assign done = (cnt_q == '0);

endmodule

`default_nettype wire

// ----- rtl/core/ohlc_dpath.sv -----
`default_nettype none

module ohlc_dpath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire ohlc_pkg::ohlc_cmd_t             cmd,
	output ohlc_pkg::ohlc_sts_t                  sts,
	input  wire logic                            cfg_we,
	input  wire logic [ohlc_pkg::SECS_BITS-1:0]  cfg_wdata,
	input  wire logic                            action,
	input  wire logic [ohlc_pkg::TIME_BITS-1:0]  trade_time,
	input  wire logic [ohlc_pkg::PRICE_BITS-1:0] trade_price,
	input  wire logic [ohlc_pkg::VOL_IN_BITS-1:0] trade_volume,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [ohlc_pkg::TIME_BITS-1:0]  bar_time,
	output logic      [ohlc_pkg::PRICE_BITS-1:0] raw_open,
	output logic      [ohlc_pkg::PRICE_BITS-1:0] raw_high,
	output logic      [ohlc_pkg::PRICE_BITS-1:0] raw_low,
	output logic      [ohlc_pkg::PRICE_BITS-1:0] raw_close,
	output logic      [ohlc_pkg::VOL_BITS-1:0]   bar_volume_sum,
	output logic      [ohlc_pkg::PRICE_BITS-1:0] smooth_open,
	output logic      [ohlc_pkg::PRICE_BITS-1:0] smooth_high,
	output logic      [ohlc_pkg::PRICE_BITS-1:0] smooth_low,
	output logic      [ohlc_pkg::PRICE_BITS-1:0] smooth_close
);
	import ohlc_pkg::*;

	// config and control state
	logic [SECS_BITS-1:0] bar_seconds_q;
	logic                 active_q;
	logic                 have_prior_q;
	logic                 out_valid_q;
	logic                 in_bar_q;

	// captured word
	logic                   flush_q;
	logic [TIME_BITS-1:0]   t_q;
	logic [PRICE_BITS-1:0]  p_q;
	logic [VOL_IN_BITS-1:0] v_q;

	// open bar
	logic [TIME_BITS-1:0]  start_q;
	logic [PRICE_BITS-1:0] open_q, high_q, low_q, close_q;
	logic [VOL_BITS-1:0]   vol_q;

	// smoothing
	logic [PRICE_BITS-1:0] prior_so_q, prior_sc_q;
	logic [PRICE_BITS-1:0] so_q, sc_q;

	logic [SECS_BITS-1:0]  len;
	logic [TIME_BITS-1:0]  diff;
	logic                  in_bar;
	logic [VOL_BITS:0]     vol_sum;
	logic [PRICE_BITS+1:0] sum4;
	logic [PRICE_BITS:0]   sum2;
	logic [PRICE_BITS-1:0] sh, sl;
	logic [SECS_BITS-1:0]  rem;
	logic                  div_done;

	// zero length counts as one second
	assign len = (bar_seconds_q == '0) ? SECS_BITS'(1) : bar_seconds_q;

	// bar membership, early trades stay in the open bar
	assign diff   = t_q - start_q;
	assign in_bar = active_q &&
		((t_q < start_q) || (diff < {{(TIME_BITS-SECS_BITS){1'b0}}, len}));

	// saturating volume sum
	assign vol_sum = {1'b0, vol_q} + {{(VOL_BITS-VOL_IN_BITS+1){1'b0}}, v_q};

	// heikin-ashi open and close
	assign sum4 = {2'b00, open_q} + {2'b00, high_q} + {2'b00, low_q} + {2'b00, close_q};
	assign sum2 = have_prior_q ? ({1'b0, prior_so_q} + {1'b0, prior_sc_q})
	                           : ({1'b0, open_q} + {1'b0, close_q});

	// heikin-ashi high and low
	always_comb begin
		sh = high_q;
		if (so_q > sh) sh = so_q;
		if (sc_q > sh) sh = sc_q;
		sl = low_q;
		if (so_q < sl) sl = so_q;
		if (sc_q < sl) sl = sc_q;
	end

	ohlc_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (t_q),
		.divisor  (len),
		.rem      (rem),
		.done     (div_done)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_seconds_q <= SECONDS_RESET;
			active_q      <= 1'b0;
			have_prior_q  <= 1'b0;
			out_valid_q   <= 1'b0;
			in_bar_q      <= 1'b0;
		end else begin
			if (cfg_we) bar_seconds_q <= cfg_wdata;
			if (cmd.check) in_bar_q <= in_bar;
			if (cmd.emit) begin
				out_valid_q  <= 1'b1;
				have_prior_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.open) active_q <= 1'b1;
			if (cmd.clear) begin
				active_q     <= 1'b0;
				have_prior_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			flush_q <= action;
			t_q     <= trade_time;
			p_q     <= trade_price;
			v_q     <= trade_volume;
		end
		if (cmd.update) begin
			if (p_q > high_q) high_q <= p_q;
			if (p_q < low_q) low_q <= p_q;
			close_q <= p_q;
			vol_q   <= vol_sum[VOL_BITS] ? '1 : vol_sum[VOL_BITS-1:0];
		end
		if (cmd.smooth) begin
			sc_q <= sum4[PRICE_BITS+1:2];
			so_q <= sum2[PRICE_BITS:1];
		end
		if (cmd.emit) begin
			prior_so_q     <= so_q;
			prior_sc_q     <= sc_q;
			bar_time       <= start_q;
			raw_open       <= open_q;
			raw_high       <= high_q;
			raw_low        <= low_q;
			raw_close      <= close_q;
			bar_volume_sum <= vol_q;
			smooth_open    <= so_q;
			smooth_high    <= sh;
			smooth_low     <= sl;
			smooth_close   <= sc_q;
		end
		if (cmd.open) begin
			start_q <= t_q - {{(TIME_BITS-SECS_BITS){1'b0}}, rem};
			open_q  <= p_q;
			high_q  <= p_q;
			low_q   <= p_q;
			close_q <= p_q;
			vol_q   <= {{(VOL_BITS-VOL_IN_BITS){1'b0}}, v_q};
		end
	end

	// status to the controller
	always_comb begin
		sts.flush    = flush_q;
		sts.in_bar   = in_bar_q;
		sts.active   = active_q;
		sts.div_done = div_done;
		sts.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/core/ohlc_ctrl.sv -----
`default_nettype none

module ohlc_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire ohlc_pkg::ohlc_sts_t sts,
	output ohlc_pkg::ohlc_cmd_t      cmd
);
	import ohlc_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_CHECK  = 8'b0000_0010,
		ST_DECIDE = 8'b0000_0100,
		ST_SMOOTH = 8'b0000_1000,
		ST_EMIT   = 8'b0001_0000,
		ST_DIV    = 8'b0010_0000,
		ST_OPEN   = 8'b0100_0000,
		ST_CLEAR  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (sts.flush) begin
					state_d = sts.active ? ST_SMOOTH : ST_CLEAR;
				end else if (sts.in_bar) begin
					cmd.update = 1'b1;
					state_d    = ST_IDLE;
				end else if (sts.active) begin
					state_d = ST_SMOOTH;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_SMOOTH: begin
				cmd.smooth = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				// hold until the output register is free
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.flush) begin
						state_d = ST_CLEAR;
					end else begin
						cmd.div_start = 1'b1;
						state_d       = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_OPEN;
			end
			ST_OPEN: begin
				cmd.open = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/core/ohlc_bar_heikin_ashi.sv -----
`default_nettype none

// channel   handshake              contents
// config    cfg_we                 cfg_wdata: bar length in seconds
// trades    in_valid / in_ready    action, trade_time, trade_price, trade_volume
// bars      out_valid / out_ready  bar_time, raw ohlc, bar_volume_sum, smooth ohlc
//
// one word at a time; a trade inside the open bar passes the capture, check and
// decide states; a trade opening a new bar waits on the bit-serial remainder
// unit (one time bit per cycle, 40 steps), after smooth and emit if it closes a bar
// a flush emits any open bar, then clears; a finished bar waits in the output
// register and only the next bar emission stalls on out_ready
// reset leaves no bar open, no smoothing history and a 600 second bar length
module ohlc_bar_heikin_ashi (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [ohlc_pkg::SECS_BITS-1:0]   cfg_wdata,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             action,
	input  wire logic [ohlc_pkg::TIME_BITS-1:0]   trade_time,
	input  wire logic [ohlc_pkg::PRICE_BITS-1:0]  trade_price,
	input  wire logic [ohlc_pkg::VOL_IN_BITS-1:0] trade_volume,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [ohlc_pkg::TIME_BITS-1:0]   bar_time,
	output logic      [ohlc_pkg::PRICE_BITS-1:0]  raw_open,
	output logic      [ohlc_pkg::PRICE_BITS-1:0]  raw_high,
	output logic      [ohlc_pkg::PRICE_BITS-1:0]  raw_low,
	output logic      [ohlc_pkg::PRICE_BITS-1:0]  raw_close,
	output logic      [ohlc_pkg::VOL_BITS-1:0]    bar_volume_sum,
	output logic      [ohlc_pkg::PRICE_BITS-1:0]  smooth_open,
	output logic      [ohlc_pkg::PRICE_BITS-1:0]  smooth_high,
	output logic      [ohlc_pkg::PRICE_BITS-1:0]  smooth_low,
	output logic      [ohlc_pkg::PRICE_BITS-1:0]  smooth_close
);
	import ohlc_pkg::*;

	ohlc_cmd_t cmd;
	ohlc_sts_t sts;

	// sequencer
	ohlc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// bar state, smoothing and output register
	ohlc_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.action         (action),
		.trade_time     (trade_time),
		.trade_price    (trade_price),
		.trade_volume   (trade_volume),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.bar_time       (bar_time),
		.raw_open       (raw_open),
		.raw_high       (raw_high),
		.raw_low        (raw_low),
		.raw_close      (raw_close),
		.bar_volume_sum (bar_volume_sum),
		.smooth_open    (smooth_open),
		.smooth_high    (smooth_high),
		.smooth_low     (smooth_low),
		.smooth_close   (smooth_close)
	);

endmodule

`default_nettype wire
